// ----- rtl/core/graph_topological_order_assert.svh -----
// Assertion macros used by the checker file.
`ifndef GRAPH_TOPOLOGICAL_ORDER_ASSERT_SVH
`define GRAPH_TOPOLOGICAL_ORDER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define GOT_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, sampled on clk, off during reset.
`define GOT_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ----- rtl/core/got_pkg.sv -----
// ----------------------------------------------------------------------------
// got_pkg
// Constants, codes and state type of the topological order block.
// ----------------------------------------------------------------------------
package got_pkg;

	localparam int MAX_NODES  = 64;
	localparam int MAX_LINKS  = 256;
	localparam int NODE_SLOTS = 64;
	localparam int NODE_W     = 6;
	localparam int DEG_W      = 9;
	localparam int CNT_W      = $clog2(NODE_SLOTS + 1);
	localparam int LINK_AW    = (MAX_LINKS > 1) ? $clog2(MAX_LINKS) : 1;
	localparam int LCNT_W     = $clog2(MAX_LINKS + 1);
	localparam int LINK_DW    = 2 * NODE_W;

	localparam logic [1:0] FN_NODE  = 2'd0;
	localparam logic [1:0] FN_LINK  = 2'd1;
	localparam logic [1:0] FN_RUN   = 2'd2;
	localparam logic [1:0] FN_CLEAR = 2'd3;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEED,
		ST_POP,
		ST_POPW,
		ST_SCAN,
		ST_OUT_RD,
		ST_OUT_CAP,
		ST_OUT_WAIT
	} got_state_t;

endpackage

// ----- rtl/core/got_ram.sv -----
// ----------------------------------------------------------------------------
// got_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module got_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- rtl/core/graph_topological_order.sv -----
// ----------------------------------------------------------------------------
// graph_topological_order
// Kahn topological sort over a loaded directed graph.
// ----------------------------------------------------------------------------
// Load items (node, link, clear) are taken one per cycle while idle;
// in-degrees are kept in a RAM updated read-modify-write with one-deep
// forwarding. A run item blocks input until its last result is taken. It
// copies in-degrees and seeds the ready queue, then for each ordered node
// pops it and walks the link RAM (one link read per cycle), then reads out
// the results in order, each held for as long as the output stalls.
// Status results (failed, empty graph) come after the same walk or at once.
module graph_topological_order (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [1:0]                 func,
	input  logic [got_pkg::NODE_W-1:0] node_index,
	input  logic [got_pkg::NODE_W-1:0] link_source,
	input  logic [got_pkg::NODE_W-1:0] link_target,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [got_pkg::NODE_W-1:0] ordered_node,
	output logic                       last,
	output logic                       failed,
	output logic                       empty_graph
);

	localparam int NW = got_pkg::NODE_W;
	localparam int DW = got_pkg::DEG_W;
	localparam int CW = got_pkg::CNT_W;
	localparam int LW = got_pkg::LCNT_W;

	got_pkg::got_state_t st_q, st_d;

	logic [got_pkg::NODE_SLOTS-1:0] present_q, deg_valid_q;
	logic [CW-1:0] nc_q, i_q, head_q, tail_q, k_q;
	logic [LW-1:0] lc_q, l_q;
	logic          err_q;

	logic          ls1_v_s1, sv_s1, a_s1, b_s2;
	logic [NW-1:0] ld_s1, si_s1, t_s2, cur_q;
	logic          dfw_q, wfw_q;
	logic [NW-1:0] dfwi_q, wfwi_q;
	logic [DW-1:0] dfwv_q, wfwv_q;

	logic          out_valid_q, last_q, failed_q, empty_q;
	logic [NW-1:0] node_q;

	logic acc_in, acc_out, link_ok, status_now, seed_done, scan_done, pop_end;
	logic [DW-1:0] deg_rdata, deg_cur, deg_inc, seed_deg, work_rdata, scan_val;
	logic [got_pkg::LINK_DW-1:0] link_rdata;
	logic [NW-1:0] lsrc, ltgt, fifo_rdata;
	logic deg_we, link_we, work_we, fifo_we, seed_push, scan_wr, scan_push, a_issue;
	logic [NW-1:0] deg_raddr, work_waddr, fifo_waddr, fifo_raddr;
	logic [DW-1:0] work_wdata;
	logic [NW-1:0] fifo_wdata;

	assign acc_in  = in_valid && in_ready;
	assign acc_out = out_valid_q && out_ready;
	assign link_ok = (lc_q < LW'(got_pkg::MAX_LINKS)) && present_q[link_source]
		&& present_q[link_target];
	assign status_now = err_q || (nc_q == '0);
	assign seed_done  = (i_q == CW'(got_pkg::MAX_NODES)) && !sv_s1;
	assign scan_done  = (l_q == lc_q) && !a_s1 && !b_s2;
	assign pop_end    = (head_q == tail_q);

	// next state
	always_comb begin
		st_d = st_q;
		case (st_q)
			got_pkg::ST_IDLE: begin
				if (acc_in && func == got_pkg::FN_RUN) begin
					st_d = status_now ? got_pkg::ST_OUT_WAIT : got_pkg::ST_SEED;
				end
			end
			got_pkg::ST_SEED: if (seed_done) st_d = got_pkg::ST_POP;
			got_pkg::ST_POP: begin
				if (!pop_end) st_d = got_pkg::ST_POPW;
				else if (tail_q != nc_q) st_d = got_pkg::ST_OUT_WAIT;
				else st_d = got_pkg::ST_OUT_RD;
			end
			got_pkg::ST_POPW:    st_d = got_pkg::ST_SCAN;
			got_pkg::ST_SCAN:    if (scan_done) st_d = got_pkg::ST_POP;
			got_pkg::ST_OUT_RD:  st_d = got_pkg::ST_OUT_CAP;
			got_pkg::ST_OUT_CAP: st_d = got_pkg::ST_OUT_WAIT;
			got_pkg::ST_OUT_WAIT: begin
				if (acc_out) st_d = last_q ? got_pkg::ST_IDLE : got_pkg::ST_OUT_RD;
			end
			default: st_d = got_pkg::ST_IDLE;
		endcase
	end

	// outputs and memory controls
	always_comb begin
		in_ready = (st_q == got_pkg::ST_IDLE);

		deg_raddr = (st_q == got_pkg::ST_SEED) ? i_q[NW-1:0] : link_target;
		if (dfw_q && dfwi_q == ld_s1) deg_cur = dfwv_q;
		else if (deg_valid_q[ld_s1]) deg_cur = deg_rdata;
		else deg_cur = '0;
		deg_inc = deg_cur + DW'(1);
		deg_we  = ls1_v_s1;

		link_we = acc_in && func == got_pkg::FN_LINK && link_ok;
		lsrc = link_rdata[2*NW-1:NW];
		ltgt = link_rdata[NW-1:0];
		a_issue = (st_q == got_pkg::ST_SCAN) && (l_q != lc_q);

		seed_deg  = deg_valid_q[si_s1] ? deg_rdata : '0;
		seed_push = sv_s1 && present_q[si_s1] && seed_deg == '0;
		scan_val  = (wfw_q && wfwi_q == t_s2) ? wfwv_q : work_rdata;
		scan_wr   = b_s2 && scan_val != '0;
		scan_push = scan_wr && scan_val == DW'(1);

		work_we    = sv_s1 || scan_wr;
		work_waddr = sv_s1 ? si_s1 : t_s2;
		work_wdata = sv_s1 ? seed_deg : scan_val - DW'(1);
		fifo_we    = seed_push || scan_push;
		fifo_waddr = tail_q[NW-1:0];
		fifo_wdata = sv_s1 ? si_s1 : t_s2;
		fifo_raddr = (st_q == got_pkg::ST_POP) ? head_q[NW-1:0] : k_q[NW-1:0];
	end

	assign out_valid    = out_valid_q;
	assign ordered_node = node_q;
	assign last         = last_q;
	assign failed       = failed_q;
	assign empty_graph  = empty_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= got_pkg::ST_IDLE;
			present_q <= '0;
			deg_valid_q <= '0;
			nc_q <= '0;
			lc_q <= '0;
			err_q <= 1'b0;
			i_q <= '0;
			head_q <= '0;
			tail_q <= '0;
			k_q <= '0;
			l_q <= '0;
			ls1_v_s1 <= 1'b0;
			sv_s1 <= 1'b0;
			a_s1 <= 1'b0;
			b_s2 <= 1'b0;
			dfw_q <= 1'b0;
			wfw_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			st_q <= st_d;
			ls1_v_s1 <= link_we;
			dfw_q <= ls1_v_s1;
			wfw_q <= scan_wr;
			// clear wins over a link update still in flight
			if (ls1_v_s1 && !(acc_in && func == got_pkg::FN_CLEAR)) begin
				deg_valid_q[ld_s1] <= 1'b1;
			end
			if (acc_in) begin
				case (func)
					got_pkg::FN_NODE: begin
						if ({1'b0, node_index} >= CW'(got_pkg::MAX_NODES)) begin
							err_q <= 1'b1;
						end else if (!present_q[node_index]) begin
							present_q[node_index] <= 1'b1;
							nc_q <= nc_q + CW'(1);
						end
					end
					got_pkg::FN_LINK: begin
						if (link_ok) lc_q <= lc_q + LW'(1);
						else err_q <= 1'b1;
					end
					got_pkg::FN_RUN: begin
						i_q <= '0;
						head_q <= '0;
						tail_q <= '0;
					end
					got_pkg::FN_CLEAR: begin
						present_q <= '0;
						deg_valid_q <= '0;
						nc_q <= '0;
						lc_q <= '0;
						err_q <= 1'b0;
					end
					default: ;
				endcase
			end
			sv_s1 <= (st_q == got_pkg::ST_SEED) && (i_q != CW'(got_pkg::MAX_NODES));
			if (st_q == got_pkg::ST_SEED && i_q != CW'(got_pkg::MAX_NODES)) begin
				i_q <= i_q + CW'(1);
			end
			if (fifo_we) tail_q <= tail_q + CW'(1);
			if (st_q == got_pkg::ST_POP && !pop_end) head_q <= head_q + CW'(1);
			if (st_q == got_pkg::ST_POPW) l_q <= '0;
			a_s1 <= a_issue;
			if (a_issue) l_q <= l_q + LW'(1);
			b_s2 <= a_s1 && lsrc == cur_q;
			if (st_q == got_pkg::ST_POP && pop_end) k_q <= '0;
			if (st_q == got_pkg::ST_OUT_WAIT && acc_out) k_q <= k_q + CW'(1);
			if (st_q == got_pkg::ST_IDLE && acc_in && func == got_pkg::FN_RUN && status_now) begin
				out_valid_q <= 1'b1;
			end
			if (st_q == got_pkg::ST_POP && pop_end && tail_q != nc_q) out_valid_q <= 1'b1;
			if (st_q == got_pkg::ST_OUT_CAP) out_valid_q <= 1'b1;
			if (acc_out) out_valid_q <= 1'b0;
		end
	end

	// payload and pipeline data
	always_ff @(posedge clk) begin
		ld_s1  <= link_target;
		si_s1  <= i_q[NW-1:0];
		t_s2   <= ltgt;
		dfwi_q <= ld_s1;
		dfwv_q <= deg_inc;
		wfwi_q <= t_s2;
		wfwv_q <= scan_val - DW'(1);
		if (st_q == got_pkg::ST_POPW) cur_q <= fifo_rdata;
		if (st_q == got_pkg::ST_IDLE && acc_in && func == got_pkg::FN_RUN && status_now) begin
			node_q   <= '0;
			last_q   <= 1'b1;
			failed_q <= err_q;
			empty_q  <= !err_q;
		end
		if (st_q == got_pkg::ST_POP && pop_end && tail_q != nc_q) begin
			node_q   <= '0;
			last_q   <= 1'b1;
			failed_q <= 1'b1;
			empty_q  <= 1'b0;
		end
		if (st_q == got_pkg::ST_OUT_CAP) begin
			node_q   <= fifo_rdata;
			last_q   <= (k_q + CW'(1)) == tail_q;
			failed_q <= 1'b0;
			empty_q  <= 1'b0;
		end
	end

	got_ram #(.WIDTH(DW), .DEPTH(got_pkg::NODE_SLOTS)) u_deg_ram (
		.clk(clk), .we(deg_we), .waddr(ld_s1), .wdata(deg_inc),
		.raddr(deg_raddr), .rdata(deg_rdata)
	);

	got_ram #(.WIDTH(DW), .DEPTH(got_pkg::NODE_SLOTS)) u_work_ram (
		.clk(clk), .we(work_we), .waddr(work_waddr), .wdata(work_wdata),
		.raddr(ltgt), .rdata(work_rdata)
	);

	got_ram #(.WIDTH(got_pkg::LINK_DW), .DEPTH(got_pkg::MAX_LINKS)) u_link_ram (
		.clk(clk), .we(link_we), .waddr(lc_q[got_pkg::LINK_AW-1:0]),
		.wdata({link_source, link_target}),
		.raddr(l_q[got_pkg::LINK_AW-1:0]), .rdata(link_rdata)
	);

	got_ram #(.WIDTH(NW), .DEPTH(got_pkg::NODE_SLOTS)) u_fifo_ram (
		.clk(clk), .we(fifo_we), .waddr(fifo_waddr), .wdata(fifo_wdata),
		.raddr(fifo_raddr), .rdata(fifo_rdata)
	);

endmodule

// ----- rtl/core/got_checker.sv -----
// ----------------------------------------------------------------------------
// got_checker
// Port-level checks of the topological order block, bound to the top level.
// ----------------------------------------------------------------------------
`include "graph_topological_order_assert.svh"

module got_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_ready,
	input logic                       out_valid,
	input logic                       out_ready,
	input logic [got_pkg::NODE_W-1:0] ordered_node,
	input logic                       last,
	input logic                       failed,
	input logic                       empty_graph
);

	`GOT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
	`GOT_ASSERT_NOW(a_no_input_during_output, out_valid, !in_ready)
	`GOT_ASSERT_NOW(a_status_is_last, out_valid && (failed || empty_graph), last)
	`GOT_ASSERT_NOW(a_status_clean, out_valid && (failed || empty_graph),
		ordered_node == '0 && !(failed && empty_graph))

endmodule

bind graph_topological_order got_checker u_got_checker (
	.clk(clk), .arst_n(arst_n), .in_ready(in_ready), .out_valid(out_valid),
	.out_ready(out_ready), .ordered_node(ordered_node), .last(last),
	.failed(failed), .empty_graph(empty_graph)
);

// ----- bench/graph_topological_order_check.sv -----
// ----------------------------------------------------------------------------
// graph_topological_order_check
// Watches both channels of the topological order block, predicts the order
// of every run item from its own copy of the graph and compares each result.
// ----------------------------------------------------------------------------
module graph_topological_order_check (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	input  logic                       in_ready,
	input  logic [1:0]                 func,
	input  logic [got_pkg::NODE_W-1:0] node_index,
	input  logic [got_pkg::NODE_W-1:0] link_source,
	input  logic [got_pkg::NODE_W-1:0] link_target,
	input  logic                       out_valid,
	input  logic                       out_ready,
	input  logic [got_pkg::NODE_W-1:0] ordered_node,
	input  logic                       last,
	input  logic                       failed,
	input  logic                       empty_graph,
	output int                         fail_count,
	output int                         pending
);
	import got_pkg::*;

	typedef struct packed {
		logic [NODE_W-1:0] node;
		logic              last;
		logic              failed;
		logic              empty;
	} order_entry_t;

	order_entry_t order_q[$];

	logic              present[NODE_SLOTS];
	logic [DEG_W-1:0]  degree[NODE_SLOTS];
	logic [NODE_W-1:0] src_store[MAX_LINKS];
	logic [NODE_W-1:0] dst_store[MAX_LINKS];
	int                link_cnt;
	int                node_cnt;
	logic              graph_err;

	initial fail_count = 0;
	assign pending = order_q.size();

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch: %s got %0d expected %0d at %0t", what, got, want, $realtime);
		fail_count++;
	endtask

	task automatic clear_graph();
		for (int i = 0; i < NODE_SLOTS; i++) begin
			present[i] = 1'b0;
			degree[i] = '0;
		end
		link_cnt = 0;
		node_cnt = 0;
		graph_err = 1'b0;
	endtask

	task automatic queue_expected(input order_entry_t e);
		order_q = {order_q, e};
	endtask

	task automatic push_status(input logic fl, input logic em);
		order_entry_t e;
		e.node = '0;
		e.last = 1'b1;
		e.failed = fl;
		e.empty = em;
		queue_expected(e);
	endtask

	task automatic predict_order();
		logic [DEG_W-1:0]  work[NODE_SLOTS];
		logic [NODE_W-1:0] fifo[NODE_SLOTS];
		logic [NODE_W-1:0] seq[NODE_SLOTS];
		logic [NODE_W-1:0] cur;
		logic [NODE_W-1:0] t;
		order_entry_t      e;
		int head;
		int tail;
		int done;
		head = 0;
		tail = 0;
		done = 0;
		if (graph_err) begin
			push_status(1'b1, 1'b0);
			return;
		end
		if (node_cnt == 0) begin
			push_status(1'b0, 1'b1);
			return;
		end
		for (int i = 0; i < NODE_SLOTS; i++) work[i] = degree[i];
		for (int i = 0; i < MAX_NODES; i++)
			if (present[i] && work[i] == 0 && tail < NODE_SLOTS) begin
				fifo[tail] = i[NODE_W-1:0];
				tail++;
			end
		while (head < tail) begin
			cur = fifo[head];
			head++;
			if (done < NODE_SLOTS) begin
				seq[done] = cur;
				done++;
			end
			for (int l = 0; l < link_cnt; l++)
				if (src_store[l] == cur) begin
					t = dst_store[l];
					if (work[t] > 0) begin
						work[t] = work[t] - 1'b1;
						if (work[t] == 0 && tail < NODE_SLOTS) begin
							fifo[tail] = t;
							tail++;
						end
					end
				end
		end
		if (done != node_cnt) begin
			push_status(1'b1, 1'b0);
			return;
		end
		for (int i = 0; i < done; i++) begin
			e.node = seq[i];
			e.last = (i + 1 == done);
			e.failed = 1'b0;
			e.empty = 1'b0;
			queue_expected(e);
		end
	endtask

	task automatic take_item(input logic [1:0] f, input logic [NODE_W-1:0] n,
			input logic [NODE_W-1:0] s, input logic [NODE_W-1:0] d);
		case (f)
			FN_NODE: begin
				if (!present[n]) begin
					present[n] = 1'b1;
					node_cnt++;
				end
			end
			FN_LINK: begin
				if (link_cnt >= MAX_LINKS || !present[s] || !present[d]) begin
					graph_err = 1'b1;
				end else begin
					src_store[link_cnt] = s;
					dst_store[link_cnt] = d;
					link_cnt++;
					degree[d] = degree[d] + 1'b1;
				end
			end
			FN_RUN: predict_order();
			default: clear_graph();
		endcase
	endtask

	initial clear_graph();

	always @(posedge clk) begin
		order_entry_t e;
		if (arst_n) begin
			if (in_valid && in_ready)
				take_item(func, node_index, link_source, link_target);
			if (out_valid && out_ready) begin
				if (order_q.size() == 0) begin
					report_mismatch("unexpected item, node", ordered_node, 0);
				end else begin
					e = order_q.pop_front();
					if (ordered_node !== e.node) report_mismatch("ordered_node", ordered_node, e.node);
					if (last !== e.last) report_mismatch("last", last, e.last);
					if (failed !== e.failed) report_mismatch("failed", failed, e.failed);
					if (empty_graph !== e.empty) report_mismatch("empty_graph", empty_graph, e.empty);
				end
			end
		end
	end

endmodule

// ----- bench/graph_topological_order_test.sv -----
// ----------------------------------------------------------------------------
// graph_topological_order_test
// Drives directed and random graphs into the topological order block under
// varying idle patterns and reports the verdict from the checker.
// ----------------------------------------------------------------------------
module graph_topological_order_test;
	import got_pkg::*;

	localparam int CYCLE_LIMIT = 2000000;
	localparam int DRAIN_WAIT  = 300;

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_ready;
	logic [1:0]        func;
	logic [NODE_W-1:0] node_index;
	logic [NODE_W-1:0] link_source;
	logic [NODE_W-1:0] link_target;
	logic              out_valid;
	logic              out_ready;
	logic [NODE_W-1:0] ordered_node;
	logic              last;
	logic              failed;
	logic              empty_graph;
	int                fail_count;
	int                pending;

	int send_idle_pct;
	int recv_idle_pct;
	int hold_req;
	int hold_seen;
	int hold_cnt;
	int item_cnt;
	int cycle_cnt;
	logic loaded[NODE_SLOTS];

	graph_topological_order u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.func(func), .node_index(node_index),
		.link_source(link_source), .link_target(link_target),
		.out_valid(out_valid), .out_ready(out_ready),
		.ordered_node(ordered_node), .last(last),
		.failed(failed), .empty_graph(empty_graph)
	);

	graph_topological_order_check u_check (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.func(func), .node_index(node_index),
		.link_source(link_source), .link_target(link_target),
		.out_valid(out_valid), .out_ready(out_ready),
		.ordered_node(ordered_node), .last(last),
		.failed(failed), .empty_graph(empty_graph),
		.fail_count(fail_count), .pending(pending)
	);

	initial clk = 1'b0;
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// Receiver: random stalls, plus a long hold-off on request.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			hold_cnt <= 0;
			hold_seen <= 0;
		end else if (hold_req != hold_seen) begin
			hold_seen <= hold_req;
			hold_cnt <= 400;
			out_ready <= 1'b0;
		end else if (hold_cnt > 0) begin
			hold_cnt <= hold_cnt - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	task automatic send_item(input logic [1:0] f, input logic [NODE_W-1:0] n,
			input logic [NODE_W-1:0] s, input logic [NODE_W-1:0] d);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		func <= f;
		node_index <= n;
		link_source <= s;
		link_target <= d;
		do @(posedge clk); while (!in_ready);
		item_cnt++;
		if (f == FN_NODE) loaded[n] = 1'b1;
		if (f == FN_LINK && !(loaded[s] && loaded[d])) ;
		if (f == FN_CLEAR)
			for (int i = 0; i < NODE_SLOTS; i++) loaded[i] = 1'b0;
	endtask

	task automatic send_node(input int n);
		send_item(FN_NODE, n, $urandom, $urandom);
	endtask

	task automatic send_link(input int s, input int d);
		send_item(FN_LINK, $urandom, s, d);
	endtask

	task automatic send_run();
		send_item(FN_RUN, $urandom, $urandom, $urandom);
	endtask

	task automatic send_clear();
		send_item(FN_CLEAR, $urandom, $urandom, $urandom);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	// Build a graph on nn random nodes; mode picks a DAG, a cycle or a bad link.
	task automatic build_and_run(input int nn, input int nl, input int mode);
		int perm[NODE_SLOTS];
		int a;
		int b;
		int tmp;
		for (int i = 0; i < NODE_SLOTS; i++) perm[i] = i;
		for (int i = NODE_SLOTS - 1; i > 0; i--) begin
			a = $urandom_range(i);
			tmp = perm[i];
			perm[i] = perm[a];
			perm[a] = tmp;
		end
		send_clear();
		for (int i = 0; i < nn; i++) send_node(perm[i]);
		if ($urandom_range(3) == 0) send_node(perm[$urandom_range(nn - 1)]);
		for (int i = 0; i < nl; i++) begin
			a = $urandom_range(nn - 1);
			b = $urandom_range(nn - 1);
			if (a > b) begin
				tmp = a;
				a = b;
				b = tmp;
			end
			if (a == b && b < nn - 1) b++;
			if (a != b) send_link(perm[a], perm[b]);
		end
		if (mode == 1) begin
			a = $urandom_range(nn - 1);
			b = $urandom_range(nn - 1);
			send_link(perm[a > b ? a : b], perm[a > b ? b : a]);
			if (a == b || nl == 0) send_link(perm[a], perm[a]);
		end else if (mode == 2 && nn < NODE_SLOTS) begin
			send_link(perm[$urandom_range(nn - 1)], perm[$urandom_range(NODE_SLOTS - 1, nn)]);
		end
		send_run();
		if ($urandom_range(4) == 0) send_run();
	endtask

	task automatic random_phase(input int target);
		int nn;
		int r;
		while (item_cnt < target) begin
			r = $urandom_range(99);
			if (r < 10) begin
				send_item($urandom, $urandom, $urandom, $urandom);
			end else begin
				nn = ($urandom_range(19) == 0) ? $urandom_range(40, 64) : $urandom_range(1, 10);
				build_and_run(nn, $urandom_range(0, 2 * nn),
					(r < 75) ? 0 : (r < 88) ? 1 : 2);
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		func = FN_NODE;
		node_index = '0;
		link_source = '0;
		link_target = '0;
		hold_req = 0;
		item_cnt = 0;
		cycle_cnt = 0;
		send_idle_pct = 17;
		recv_idle_pct = 46;
		for (int i = 0; i < NODE_SLOTS; i++) loaded[i] = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty graph, extremes, cycle, self loop
		send_run();
		send_node(63);
		send_node(0);
		send_node(0);
		send_run();
		send_link(0, 63);
		send_run();
		send_link(63, 0);
		send_run();
		send_clear();
		send_node(3);
		send_link(3, 3);
		send_run();
		// link to an unloaded node, error persists
		send_clear();
		send_node(5);
		send_link(5, 7);
		send_run();
		send_node(7);
		send_run();
		send_clear();
		send_run();
		// link store overflow
		send_clear();
		send_node(0);
		send_node(1);
		for (int i = 0; i <= MAX_LINKS; i++) send_link(0, 1);
		send_run();
		wait_drained();

		random_phase(300);
		// long receiver hold-off while the sender keeps offering
		send_clear();
		for (int i = 0; i < NODE_SLOTS; i++) send_node(i);
		for (int i = 0; i < 20; i++) send_link(i, i + 30);
		hold_req = hold_req + 1;
		send_run();
		send_clear();
		wait_drained();
		random_phase(400);

		send_idle_pct = 46;
		recv_idle_pct = 17;
		random_phase(430);
		wait_drained();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		random_phase(460);
		wait_drained();

		if (fail_count == 0 && pending == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
